[rtl/kvm_pkg.sv]
// kvm_pkg: shared types and constants for the key/value map core.
// Used by kvm_cell, array_key_value_map_core and kvm_core_chk; no dependencies.

package kvm_pkg;

    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int DATA_W    = 32;
    localparam int KIND_W    = 3;
    localparam int CNT_OUT_W = 5;
    localparam int S_DATA_W  = 64;
    localparam int M_DATA_W  = 72;

    typedef enum logic [KIND_W-1:0] {
        K_ADD    = 3'd0,
        K_REMOVE = 3'd1,
        K_LOOKUP = 3'd2,
        K_CLEAR  = 3'd3,
        K_REWIND = 3'd4,
        K_NEXT   = 3'd5,
        K_PREV   = 3'd6
    } t_kind;

    // spare kind code, no operation
    localparam logic [KIND_W-1:0] K_UNUSED = 3'd7;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              find;
        logic              rm;
        logic              seek;
        logic [KEY_W-1:0]  qkey;
        logic              wr;
        logic [KEY_W-1:0]  wkey;
        logic [VAL_W-1:0]  wval;
    } t_bcast;

    // search token handed from cell to cell
    typedef struct packed {
        logic              vld;
        logic              found;
        logic [DATA_W-1:0] data;
    } t_tok;

endpackage

[rtl/kvm_cell.sv]
// kvm_cell: one table entry plus one stage of the search token chain.
// Depends on kvm_pkg.

module kvm_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  kvm_pkg::t_bcast           i_cmd,
    input  logic [CNT_W-1:0]          i_count,
    input  logic [CNT_W-1:0]          i_target,
    input  kvm_pkg::t_tok             i_tok,
    input  logic [CNT_W-1:0]          i_tok_idx,
    input  logic [kvm_pkg::KEY_W-1:0] i_nxt_key,
    input  logic [kvm_pkg::VAL_W-1:0] i_nxt_val,
    output logic [kvm_pkg::KEY_W-1:0] o_key,
    output logic [kvm_pkg::VAL_W-1:0] o_val,
    output kvm_pkg::t_tok             o_tok,
    output logic [CNT_W-1:0]          o_tok_idx
);

    localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] NXT_IDX = CNT_W'(IDX + 1);

    logic [kvm_pkg::KEY_W-1:0] r_key;
    logic [kvm_pkg::VAL_W-1:0] r_val;
    kvm_pkg::t_tok             r_tok;
    logic [CNT_W-1:0]          r_tok_idx;

    logic live, match, hit, found, shift, wr;

    always_comb begin
        live  = MY_IDX < i_count;
        match = i_cmd.seek ? (i_target == MY_IDX)
                           : (i_cmd.find && live && (r_key == i_cmd.qkey));
        hit   = i_tok.vld && !i_tok.found && match;
        found = i_tok.found || hit;
        shift = i_tok.vld && i_cmd.rm && found && (NXT_IDX < i_count);
        wr    = i_cmd.wr && (i_count == MY_IDX);
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_key <= i_cmd.wkey;
            r_val <= i_cmd.wval;
        end else if (shift) begin
            r_key <= i_nxt_key;
            r_val <= i_nxt_val;
        end
        r_tok.found <= found;
        if (hit) begin
            r_tok.data <= i_cmd.seek ? r_key : r_val;
            r_tok_idx  <= MY_IDX;
        end else begin
            r_tok.data <= i_tok.data;
            r_tok_idx  <= i_tok_idx;
        end
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= i_tok.vld;
        end
    end

    assign o_key     = r_key;
    assign o_val     = r_val;
    assign o_tok     = r_tok;
    assign o_tok_idx = r_tok_idx;

endmodule

[rtl/array_key_value_map_core.sv]
// array_key_value_map_core: key/value table as a row of DEPTH entry cells.
// Depends on kvm_pkg and kvm_cell.
//
//   channel   dir   handshake               contents
//   s         in    i_s_tvalid/o_s_tready   tuser kind, tdata key_in, value_in
//   m         out   o_m_tvalid/i_m_tready   tdata ok, value_out, key_out, entry_count
//
// Add, clear, rewind, unused kinds and failing cursor moves: the result is registered
// in the cycle after acceptance. Lookup, remove and valid next/prev: the search token
// walks the cell row one cell a cycle; the result is registered as it leaves the last
// cell, and the next word is taken after the result. Reset empties the table; the stores
// are not cleared. A word is taken only in S_IDLE when the result register is free or being emptied.

module array_key_value_map_core #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [31:0] key_in, [63:32] value_in
    input  logic [kvm_pkg::S_DATA_W-1:0]  i_s_tdata,
    // [2:0] kind
    input  logic [kvm_pkg::KIND_W-1:0]    i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [0] ok, [32:1] value_out, [64:33] key_out, [69:65] entry_count, [71:70] zero
    output logic [kvm_pkg::M_DATA_W-1:0]  o_m_tdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    typedef enum logic {S_IDLE, S_SCAN} t_state;

    t_state                    r_state;
    logic [CNT_W-1:0]          r_count, r_cursor, r_target;
    logic                      r_find, r_rm, r_seek, r_launch;
    logic [kvm_pkg::KEY_W-1:0] r_qkey;
    logic                      r_out_vld, r_ok;
    logic [kvm_pkg::VAL_W-1:0] r_vout;
    logic [kvm_pkg::KEY_W-1:0] r_kout;
    logic [CNT_W-1:0]          r_cnt_out;

    kvm_pkg::t_bcast           c_cmd;
    kvm_pkg::t_tok             tok     [DEPTH+1];
    logic [CNT_W-1:0]          tok_idx [DEPTH+1];
    logic [kvm_pkg::KEY_W-1:0] c_key   [DEPTH];
    logic [kvm_pkg::VAL_W-1:0] c_val   [DEPTH];

    logic                      s_acc;
    kvm_pkg::t_kind            kind;
    logic [CNT_W:0]            cur_inc;
    logic [CNT_W-1:0]          cur_dec;
    logic [CNT_W+kvm_pkg::CNT_OUT_W-1:0] cnt_ext;

    assign o_s_tready = (r_state == S_IDLE) && (!r_out_vld || i_m_tready);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign kind       = kvm_pkg::t_kind'(i_s_tuser);
    assign cur_inc    = {1'b0, r_cursor} + (CNT_W+1)'(1);
    assign cur_dec    = r_cursor - CNT_W'(1);

    always_comb begin
        c_cmd.find = r_find;
        c_cmd.rm   = r_rm;
        c_cmd.seek = r_seek;
        c_cmd.qkey = r_qkey;
        c_cmd.wr   = s_acc && (kind == kvm_pkg::K_ADD) && (r_count < FULL);
        c_cmd.wkey = i_s_tdata[kvm_pkg::KEY_W-1:0];
        c_cmd.wval = i_s_tdata[kvm_pkg::KEY_W+kvm_pkg::VAL_W-1:kvm_pkg::KEY_W];
    end

    assign tok[0]     = '{vld: r_launch, found: 1'b0, data: '0};
    assign tok_idx[0] = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [kvm_pkg::KEY_W-1:0] nxt_key;
        logic [kvm_pkg::VAL_W-1:0] nxt_val;
        if (i == DEPTH - 1) begin : g_end
            assign nxt_key = '0;
            assign nxt_val = '0;
        end else begin : g_mid
            assign nxt_key = c_key[i+1];
            assign nxt_val = c_val[i+1];
        end
        kvm_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (c_cmd),
            .i_count   (r_count),
            .i_target  (r_target),
            .i_tok     (tok[i]),
            .i_tok_idx (tok_idx[i]),
            .i_nxt_key (nxt_key),
            .i_nxt_val (nxt_val),
            .o_key     (c_key[i]),
            .o_val     (c_val[i]),
            .o_tok     (tok[i+1]),
            .o_tok_idx (tok_idx[i+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cursor  <= '0;
            r_launch  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_launch <= 1'b0;
            if (o_m_tvalid && i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_ok      <= 1'b0;
                        r_vout    <= '0;
                        r_kout    <= '0;
                        r_cnt_out <= r_count;
                        r_out_vld <= 1'b1;
                        unique case (kind) inside
                            kvm_pkg::K_ADD: begin
                                if (r_count < FULL) begin
                                    r_count   <= r_count + CNT_W'(1);
                                    r_cursor  <= r_count + CNT_W'(1);
                                    r_cnt_out <= r_count + CNT_W'(1);
                                    r_ok      <= 1'b1;
                                end
                            end
                            kvm_pkg::K_CLEAR: begin
                                r_count   <= '0;
                                r_cursor  <= '0;
                                r_cnt_out <= '0;
                                r_ok      <= 1'b1;
                            end
                            kvm_pkg::K_REWIND: begin
                                r_cursor <= '0;
                                r_ok     <= 1'b1;
                            end
                            kvm_pkg::K_REMOVE, kvm_pkg::K_LOOKUP: begin
                                r_find    <= 1'b1;
                                r_rm      <= (kind == kvm_pkg::K_REMOVE);
                                r_seek    <= 1'b0;
                                r_qkey    <= i_s_tdata[kvm_pkg::KEY_W-1:0];
                                r_launch  <= 1'b1;
                                r_out_vld <= 1'b0;
                                r_state   <= S_SCAN;
                            end
                            kvm_pkg::K_NEXT: begin
                                if (cur_inc < {1'b0, r_count}) begin
                                    r_find    <= 1'b0;
                                    r_rm      <= 1'b0;
                                    r_seek    <= 1'b1;
                                    r_target  <= cur_inc[CNT_W-1:0];
                                    r_launch  <= 1'b1;
                                    r_out_vld <= 1'b0;
                                    r_state   <= S_SCAN;
                                end
                            end
                            kvm_pkg::K_PREV: begin
                                if ((r_cursor != '0) && (cur_dec < r_count)) begin
                                    r_find    <= 1'b0;
                                    r_rm      <= 1'b0;
                                    r_seek    <= 1'b1;
                                    r_target  <= cur_dec;
                                    r_launch  <= 1'b1;
                                    r_out_vld <= 1'b0;
                                    r_state   <= S_SCAN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (tok[DEPTH].vld) begin
                        r_state   <= S_IDLE;
                        r_out_vld <= 1'b1;
                        r_vout    <= '0;
                        r_kout    <= '0;
                        r_cnt_out <= r_count;
                        if (r_seek) begin
                            r_ok     <= 1'b1;
                            r_kout   <= tok[DEPTH].data[kvm_pkg::KEY_W-1:0];
                            r_cursor <= r_target;
                        end else begin
                            r_ok <= tok[DEPTH].found;
                            if (tok[DEPTH].found) begin
                                r_cursor <= tok_idx[DEPTH];
                                if (r_rm) begin
                                    r_count   <= r_count - CNT_W'(1);
                                    r_cnt_out <= r_count - CNT_W'(1);
                                end else begin
                                    r_vout <= tok[DEPTH].data[kvm_pkg::VAL_W-1:0];
                                end
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign cnt_ext    = {kvm_pkg::CNT_OUT_W'(0), r_cnt_out};
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {2'b00, cnt_ext[kvm_pkg::CNT_OUT_W-1:0], r_kout, r_vout, r_ok};

endmodule

[rtl/kvm_core_chk.sv]
// kvm_core_chk: port-level checks for array_key_value_map_core, bound into that module.
// Depends on kvm_pkg.

module kvm_core_chk #(
    parameter int DEPTH = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_tvalid,
    input logic                         o_s_tready,
    input logic [kvm_pkg::S_DATA_W-1:0] i_s_tdata,
    input logic [kvm_pkg::KIND_W-1:0]   i_s_tuser,
    input logic                         o_m_tvalid,
    input logic                         i_m_tready,
    input logic [kvm_pkg::M_DATA_W-1:0] o_m_tdata
);

    logic [kvm_pkg::CNT_OUT_W-1:0] cnt;
    logic                          fail_zero;
    logic                          nop_word;

    assign cnt       = o_m_tdata[69:65];
    assign fail_zero = (o_m_tdata[32:1] == '0) && (o_m_tdata[64:33] == '0);
    assign nop_word  = i_s_tvalid && o_s_tready && (i_s_tuser == kvm_pkg::K_UNUSED)
                       && (i_s_tdata == i_s_tdata);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (!o_m_tvalid || i_m_tready))
        else $error("input taken while result register is blocked");

    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> fail_zero)
        else $error("failed operation returned data");

    a_nop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        nop_word |=> o_m_tvalid && !o_m_tdata[0] && fail_zero)
        else $error("unused kind did not give an immediate failed result");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (DEPTH > 31) || (int'(cnt) <= DEPTH))
        else $error("entry count above table depth");

endmodule

bind array_key_value_map_core kvm_core_chk #(
    .DEPTH (DEPTH)
) u_kvm_core_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

[tb/array_key_value_map_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for array_key_value_map_core: drives table operations
// and predicts each result, checking every field of each output word in order.
// Depends on kvm_pkg and the core RTL only.

module array_key_value_map_core_tb;

    localparam int DEPTH = 16;

    typedef struct packed {
        logic                          ok;
        logic [kvm_pkg::VAL_W-1:0]     value;
        logic [kvm_pkg::KEY_W-1:0]     key;
        logic [kvm_pkg::CNT_OUT_W-1:0] count;
    } t_map_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [kvm_pkg::S_DATA_W-1:0]   i_s_tdata = '0;
    logic [kvm_pkg::KIND_W-1:0]     i_s_tuser = '0;
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [kvm_pkg::M_DATA_W-1:0]   o_m_tdata;

    logic [kvm_pkg::KEY_W-1:0] key_tbl [DEPTH];
    logic [kvm_pkg::VAL_W-1:0] val_tbl [DEPTH];
    int                        fill_cnt = 0;
    int                        cur_pos = 0;
    t_map_result               owed_results [$];
    t_map_result               want_res;
    int                        err_cnt = 0;
    bit                        idle_on = 1'b1;
    int                        rx_hold = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    array_key_value_map_core #(.DEPTH(DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // updates the shadow table and returns what the core should answer
    function automatic t_map_result map_apply(logic [kvm_pkg::KIND_W-1:0] kind,
                                              logic [kvm_pkg::KEY_W-1:0] key,
                                              logic [kvm_pkg::VAL_W-1:0] val);
        t_map_result r;
        int          hit;
        r = '0;
        hit = -1;
        for (int i = fill_cnt - 1; i >= 0; i--) begin
            if (key_tbl[i] == key) hit = i;
        end
        case (kind)
            kvm_pkg::K_ADD: begin
                if (fill_cnt < DEPTH) begin
                    key_tbl[fill_cnt] = key;
                    val_tbl[fill_cnt] = val;
                    fill_cnt++;
                    cur_pos = fill_cnt;
                    r.ok = 1'b1;
                end
            end
            kvm_pkg::K_REMOVE: begin
                if (hit >= 0) begin
                    for (int i = hit; i < fill_cnt - 1; i++) begin
                        key_tbl[i] = key_tbl[i + 1];
                        val_tbl[i] = val_tbl[i + 1];
                    end
                    fill_cnt--;
                    cur_pos = hit;
                    r.ok = 1'b1;
                end
            end
            kvm_pkg::K_LOOKUP: begin
                if (hit >= 0) begin
                    cur_pos = hit;
                    r.value = val_tbl[hit];
                    r.ok = 1'b1;
                end
            end
            kvm_pkg::K_CLEAR: begin
                fill_cnt = 0;
                cur_pos = 0;
                r.ok = 1'b1;
            end
            kvm_pkg::K_REWIND: begin
                cur_pos = 0;
                r.ok = 1'b1;
            end
            kvm_pkg::K_NEXT: begin
                if (cur_pos + 1 < fill_cnt) begin
                    cur_pos++;
                    r.key = key_tbl[cur_pos];
                    r.ok = 1'b1;
                end
            end
            kvm_pkg::K_PREV: begin
                if (cur_pos >= 1 && cur_pos - 1 < fill_cnt) begin
                    cur_pos--;
                    r.key = key_tbl[cur_pos];
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = kvm_pkg::CNT_OUT_W'(fill_cnt);
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("tb: mismatch on %s: got %h, want %h", field, got, want);
        err_cnt++;
    endtask

    // offers one word, returns at the edge where it is taken
    task automatic send_op(input logic [kvm_pkg::KIND_W-1:0] kind,
                           input logic [kvm_pkg::KEY_W-1:0] key,
                           input logic [kvm_pkg::VAL_W-1:0] val);
        if (idle_on) begin
            while ($urandom_range(99) < 26) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {val, key};
        do @(posedge i_clk); while (!o_s_tready);
        owed_results.push_back(map_apply(kind, key, val));
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (owed_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            i_m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else if (idle_on && $urandom_range(99) < 26) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (owed_results.size() == 0) begin
                note_mismatch("unexpected word", o_m_tdata[31:0], '0);
            end else begin
                want_res = owed_results.pop_front();
                if (o_m_tdata[0] !== want_res.ok)
                    note_mismatch("ok", 32'(o_m_tdata[0]), 32'(want_res.ok));
                if (o_m_tdata[32:1] !== want_res.value)
                    note_mismatch("value_out", o_m_tdata[32:1], want_res.value);
                if (o_m_tdata[64:33] !== want_res.key)
                    note_mismatch("key_out", o_m_tdata[64:33], want_res.key);
                if (o_m_tdata[69:65] !== want_res.count)
                    note_mismatch("entry_count", 32'(o_m_tdata[69:65]),
                                  32'(want_res.count));
                if (o_m_tdata[71:70] !== 2'b00)
                    note_mismatch("padding", 32'(o_m_tdata[71:70]), '0);
            end
        end
    end

    task automatic test_empty_table();
        send_op(kvm_pkg::K_NEXT, '0, '0);
        send_op(kvm_pkg::K_PREV, '1, '1);
        send_op(kvm_pkg::K_LOOKUP, '0, '1);
        send_op(kvm_pkg::K_REMOVE, '1, '0);
        send_op(kvm_pkg::K_UNUSED, '1, '1);
        send_op(kvm_pkg::K_REWIND, $urandom, $urandom);
        send_op(kvm_pkg::K_CLEAR, $urandom, $urandom);
    endtask

    // fills to the brim with a duplicated key, then overflows and works on the duplicate
    task automatic test_full_table();
        logic [kvm_pkg::KEY_W-1:0] dup_key;
        dup_key = $urandom;
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0)
                send_op(kvm_pkg::K_ADD, '0, '1);
            else if (i == 1)
                send_op(kvm_pkg::K_ADD, '1, '0);
            else if (i == 3 || i == 5)
                send_op(kvm_pkg::K_ADD, dup_key, $urandom);
            else
                send_op(kvm_pkg::K_ADD, $urandom, $urandom);
        end
        send_op(kvm_pkg::K_ADD, '1, '1);
        send_op(kvm_pkg::K_LOOKUP, dup_key, '0);
        send_op(kvm_pkg::K_PREV, '0, '0);
        send_op(kvm_pkg::K_REMOVE, dup_key, '0);
        send_op(kvm_pkg::K_NEXT, '0, '0);
        send_op(kvm_pkg::K_LOOKUP, dup_key, '0);
        send_op(kvm_pkg::K_CLEAR, '0, '0);
    endtask

    // output held off while words keep coming, so the core stalls its input
    task automatic test_backpressure();
        rx_hold = 200;
        for (int n = 0; n < 40; n++)
            send_op((n % 3 == 0) ? kvm_pkg::K_LOOKUP : kvm_pkg::K_ADD,
                    $urandom_range(3), $urandom);
    endtask

    task automatic test_random_mix(input int n_ops);
        logic [kvm_pkg::KIND_W-1:0] kind;
        logic [kvm_pkg::KEY_W-1:0]  key;
        logic [kvm_pkg::KEY_W-1:0]  key_pool [8];
        int                         roll;
        int                         cut;
        bit                         fill_heavy;
        for (int p = 0; p < 8; p++) key_pool[p] = $urandom;
        fill_heavy = 1'b1;
        for (int n = 0; n < n_ops; n++) begin
            if (n % 50 == 0) begin
                fill_heavy = $urandom_range(1);
                key_pool[$urandom_range(7)] = $urandom;
                key_pool[$urandom_range(7)] = $urandom;
            end
            roll = $urandom_range(99);
            cut  = fill_heavy ? 48 : 20;
            if (roll < cut)
                kind = kvm_pkg::K_ADD;
            else if (roll < cut + (fill_heavy ? 10 : 33))
                kind = kvm_pkg::K_REMOVE;
            else if (roll < (fill_heavy ? 75 : 70))
                kind = kvm_pkg::K_LOOKUP;
            else if (roll < (fill_heavy ? 86 : 81))
                kind = kvm_pkg::K_NEXT;
            else if (roll < (fill_heavy ? 94 : 89))
                kind = kvm_pkg::K_PREV;
            else if (roll < (fill_heavy ? 97 : 92))
                kind = kvm_pkg::K_REWIND;
            else if (roll < (fill_heavy ? 98 : 95))
                kind = kvm_pkg::K_CLEAR;
            else
                kind = kvm_pkg::K_UNUSED;
            key = ($urandom_range(3) != 0) ? key_pool[$urandom_range(7)] : $urandom;
            send_op(kind, key, $urandom);
        end
    endtask

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_full_table();
        wait_drained();
        test_backpressure();
        wait_drained();
        test_random_mix(1300);
        idle_on = 1'b0;
        test_random_mix(300);
        idle_on = 1'b1;
        test_random_mix(100);
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/kvm_pkg.sv
rtl/kvm_cell.sv
rtl/array_key_value_map_core.sv
rtl/kvm_core_chk.sv
tb/array_key_value_map_core_tb.sv
